@@ hdl/dts_pkg.sv @@
`timescale 1ns / 1ps

package dts_pkg;

    localparam int VOICES       = 14;
    localparam int SINE_ENTRIES = 1024;
    localparam int SINE_BITS    = $clog2(SINE_ENTRIES);
    localparam int VOX_W        = (VOICES > 1) ? $clog2(VOICES) : 1;

    localparam int LVL_W     = 28;
    localparam int PH_W      = 32;
    localparam int SIN_W     = 16;
    localparam int DEC_W     = 16;
    localparam int CFG_W     = 28;
    localparam int CFG_IDX_W = 2;
    localparam int KEY_W     = 8;
    localparam int SAMPLE_W  = 32;
    localparam int TERM_W    = LVL_W + SIN_W + 1;
    localparam int SUM_RAW_W = LVL_W + $clog2(VOICES + 1) + 2;
    localparam int SUM_W     = (SUM_RAW_W > SAMPLE_W + 1) ? SUM_RAW_W : SAMPLE_W + 1;

    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_W     = 34;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int SIN_FRAC     = 15;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = CORDIC_W'(652032874);
    localparam logic signed [CORDIC_W-1:0] QUARTER     = CORDIC_W'(1073741824);
    localparam logic signed [CORDIC_W-1:0] HALF        = CORDIC_W'(64'd2147483648);
    localparam logic signed [CORDIC_W-1:0] SIN_MAX     = CORDIC_W'(32767);

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_KEY  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_VOL = 2'd0,
        CFG_MIN_VOL = 2'd1,
        CFG_DECAY   = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        FL_LOAD,
        FL_ITER,
        FL_WRITE,
        FL_DONE
    } t_fill_state;

    typedef struct packed {
        logic             hit;
        logic [KEY_W-1:0] vox;
    } t_key_map;

    function automatic t_key_map key_to_voice(input logic [KEY_W-1:0] code);
        t_key_map m;
        m.hit = 1'b0;
        m.vox = '0;
        if (code >= 8'd3 && code <= 8'd8 && code != 8'd5) begin
            m.hit = 1'b1;
            m.vox = code - 8'd3;
        end else if (code >= 8'd16 && code <= 8'd23) begin
            m.hit = 1'b1;
            m.vox = code - 8'd10;
        end
        if (m.vox >= KEY_W'(VOICES)) begin
            m.hit = 1'b0;
        end
        return m;
    endfunction

    // Equal tempered C4..C5 steps at 8 kHz; the unused slot and voices past C5 hold still.
    function automatic logic [PH_W-1:0] note_step(input logic [KEY_W-1:0] vox);
        logic [PH_W-1:0] s;
        case (vox)
            8'd0:    s = 32'd140459174;
            8'd1:    s = 32'd148811275;
            8'd2:    s = 32'd0;
            8'd3:    s = 32'd157660089;
            8'd4:    s = 32'd167035036;
            8'd5:    s = 32'd176967470;
            8'd6:    s = 32'd187490462;
            8'd7:    s = 32'd198639231;
            8'd8:    s = 32'd210450928;
            8'd9:    s = 32'd222965013;
            8'd10:   s = 32'd236223201;
            8'd11:   s = 32'd250269784;
            8'd12:   s = 32'd265151578;
            8'd13:   s = 32'd280918295;
            default: s = 32'd0;
        endcase
        return s;
    endfunction

    // Arctangent of 2^-i as a fraction of a full turn, 2^32 per turn.
    function automatic logic signed [CORDIC_W-1:0] atan_turn(input logic [STEP_W-1:0] i);
        logic signed [CORDIC_W-1:0] a;
        case (i)
            5'd0:    a = CORDIC_W'(536870912);
            5'd1:    a = CORDIC_W'(316933406);
            5'd2:    a = CORDIC_W'(167458907);
            5'd3:    a = CORDIC_W'(85004756);
            5'd4:    a = CORDIC_W'(42667331);
            5'd5:    a = CORDIC_W'(21354465);
            5'd6:    a = CORDIC_W'(10679838);
            5'd7:    a = CORDIC_W'(5340245);
            5'd8:    a = CORDIC_W'(2670163);
            5'd9:    a = CORDIC_W'(1335087);
            5'd10:   a = CORDIC_W'(667544);
            5'd11:   a = CORDIC_W'(333772);
            5'd12:   a = CORDIC_W'(166886);
            5'd13:   a = CORDIC_W'(83443);
            5'd14:   a = CORDIC_W'(41722);
            5'd15:   a = CORDIC_W'(20861);
            5'd16:   a = CORDIC_W'(10430);
            5'd17:   a = CORDIC_W'(5215);
            5'd18:   a = CORDIC_W'(2608);
            5'd19:   a = CORDIC_W'(1304);
            5'd20:   a = CORDIC_W'(652);
            5'd21:   a = CORDIC_W'(326);
            5'd22:   a = CORDIC_W'(163);
            5'd23:   a = CORDIC_W'(81);
            default: a = '0;
        endcase
        return a;
    endfunction

    // Arithmetic shift right that rounds toward zero.
    function automatic logic signed [CORDIC_W-1:0] shr_tz(
        input logic signed [CORDIC_W-1:0] v,
        input logic [STEP_W-1:0]          s
    );
        logic [CORDIC_W-1:0] mag;
        mag = v[CORDIC_W-1] ? $unsigned(-v) : $unsigned(v);
        mag = mag >> s;
        return v[CORDIC_W-1] ? -$signed(mag) : $signed(mag);
    endfunction

endpackage

@@ hdl/dts_sine.sv @@
`timescale 1ns / 1ps

module dts_sine import dts_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [SINE_BITS-1:0]        i_rd_addr,
    output logic signed [SIN_W-1:0]     o_rd_data,
    output logic                        o_ready
);

    t_fill_state r_state, n_state;

    logic [SINE_BITS-1:0]        r_idx;
    logic [STEP_W-1:0]           r_step;
    logic signed [CORDIC_W-1:0]  r_x, r_y, r_z;
    logic                        r_neg;
    logic signed [SIN_W-1:0]     r_mem [SINE_ENTRIES];
    logic signed [SIN_W-1:0]     r_rd_data;

    logic [PH_W-1:0]             angle;
    logic signed [CORDIC_W-1:0]  a_ext, a_fold;
    logic                        a_neg;
    logic signed [CORDIC_W-1:0]  xs, ys, at;
    logic signed [CORDIC_W-1:0]  s_raw, s_clip, s_out;
    logic                        idx_last, step_last;

    assign angle    = {r_idx, {(PH_W - SINE_BITS){1'b0}}};
    assign a_ext    = CORDIC_W'($signed(angle));
    assign idx_last = (r_idx == SINE_BITS'(SINE_ENTRIES - 1));
    assign step_last = (r_step == STEP_W'(CORDIC_STEPS - 1));

    // fold the angle into the right half plane, flip the sign at the end
    always_comb begin
        a_fold = a_ext;
        a_neg  = 1'b0;
        if (a_ext > QUARTER) begin
            a_fold = a_ext - HALF;
            a_neg  = 1'b1;
        end else if (a_ext < -QUARTER) begin
            a_fold = a_ext + HALF;
            a_neg  = 1'b1;
        end
    end

    assign xs = shr_tz(r_x, r_step);
    assign ys = shr_tz(r_y, r_step);
    assign at = atan_turn(r_step);

    always_comb begin
        s_raw  = shr_tz(r_y, STEP_W'(SIN_FRAC));
        s_clip = s_raw;
        if (s_raw > SIN_MAX) begin
            s_clip = SIN_MAX;
        end else if (s_raw < -SIN_MAX) begin
            s_clip = -SIN_MAX;
        end
        s_out = r_neg ? -s_clip : s_clip;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FL_LOAD:  n_state = FL_ITER;
            FL_ITER:  n_state = step_last ? FL_WRITE : FL_ITER;
            FL_WRITE: n_state = idx_last ? FL_DONE : FL_LOAD;
            FL_DONE:  n_state = FL_DONE;
            default:  n_state = FL_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FL_LOAD;
            r_idx   <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == FL_LOAD) begin
                r_step <= '0;
            end else if (r_state == FL_ITER) begin
                r_step <= r_step + 1'b1;
            end
            if (r_state == FL_WRITE && !idx_last) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == FL_LOAD) begin
            r_x   <= CORDIC_GAIN;
            r_y   <= '0;
            r_z   <= a_fold;
            r_neg <= a_neg;
        end else if (r_state == FL_ITER) begin
            if (!r_z[CORDIC_W-1]) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + at;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == FL_WRITE) begin
            r_mem[r_idx] <= SIN_W'(s_out);
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
    assign o_ready   = (r_state == FL_DONE);

endmodule

@@ hdl/decaying_tone_synth_core.sv @@
`timescale 1ns / 1ps

// Polyphonic sine synthesizer, 14 voices. After reset the sine table (1024 entries,
// Q15) is built by an iterative CORDIC, one entry at a time, and no request is taken
// until the table is done; configuration writes are taken throughout. A key-press
// request (func = 1) loads the configured peak level (register 0) into the voice its
// key code selects and yields no sample. A tick request (func = 0) walks the voice
// level and phase memories one voice per cycle through a four-stage read, sine
// lookup, multiply and accumulate pipeline; the saturated sum lands in the output
// register once that register is free, and the next request is taken after that.
// Phases advance and levels decay on the way. The next request is taken while a
// sample waits in the output register.
module decaying_tone_synth_core import dts_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_func,
    input  logic [KEY_W-1:0]            i_key_code,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [SAMPLE_W-1:0]  o_sample,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_W-1:0]            i_cfg_data
);

    t_state r_state, n_state;

    logic [LVL_W-1:0]   r_max_vol, r_min_vol;
    logic [DEC_W-1:0]   r_decay;

    logic [LVL_W-1:0]   r_lvl_mem [VOICES];
    logic [PH_W-1:0]    r_ph_mem  [VOICES];
    logic [VOICES-1:0]  r_lvl_vld, r_ph_vld;
    logic [LVL_W-1:0]   r_lvl_q;
    logic [PH_W-1:0]    r_ph_q;
    logic               r_lvl_ok, r_ph_ok;

    logic [VOX_W-1:0]   r_issue;
    logic               r_s1_vld, r_s1_last;
    logic [VOX_W-1:0]   r_s1_vox;
    logic               r_s2_vld, r_s2_last;
    logic [LVL_W-1:0]   r_s2_lvl;
    logic               r_s3_vld, r_s3_last;
    logic signed [TERM_W-1:0] r_s3_term;
    logic signed [SUM_W-1:0]  r_acc;
    logic               r_out_vld;
    logic signed [SAMPLE_W-1:0] r_sample;

    logic               sine_ready;
    logic signed [SIN_W-1:0] sine_data;
    logic [SINE_BITS-1:0]    sine_addr;

    logic               in_take, tick_start, key_wr, issue_last, out_load;
    t_key_map           key;
    logic [LVL_W-1:0]   s1_lvl, dec_lvl, new_lvl;
    logic [PH_W-1:0]    s1_ph, new_ph;
    logic [LVL_W+DEC_W-1:0] dec_prod;
    logic               lvl_we;
    logic [VOX_W-1:0]   lvl_wa;
    logic [LVL_W-1:0]   lvl_wd;
    logic signed [TERM_W-1:0] term_c;
    logic [TERM_W-1:0]  term_mag;
    logic signed [TERM_W-1:0] term_tz;
    logic signed [SAMPLE_W-1:0] sat;

    dts_sine u_sine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (sine_addr),
        .o_rd_data (sine_data),
        .o_ready   (sine_ready)
    );

    assign o_in_stall = (r_state != ST_IDLE) || !sine_ready;
    assign in_take    = i_in_valid && !o_in_stall;
    assign tick_start = in_take && (i_func == FUNC_TICK);
    assign key        = key_to_voice(i_key_code);
    assign key_wr     = in_take && (i_func == FUNC_KEY) && key.hit;
    assign issue_last = (r_issue == VOX_W'(VOICES - 1));
    assign out_load   = (r_state == ST_DONE) && (!r_out_vld || !i_out_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  n_state = tick_start ? ST_RUN : ST_IDLE;
            ST_RUN:   n_state = issue_last ? ST_DRAIN : ST_RUN;
            ST_DRAIN: n_state = (r_s3_vld && r_s3_last) ? ST_DONE : ST_DRAIN;
            ST_DONE:  n_state = out_load ? ST_IDLE : ST_DONE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // stage 1: memory data back, decay the level, advance the phase, write back
    assign s1_lvl    = r_lvl_ok ? r_lvl_q : '0;
    assign s1_ph     = r_ph_ok ? r_ph_q : '0;
    assign dec_prod  = (LVL_W+DEC_W)'(s1_lvl) * (LVL_W+DEC_W)'(r_decay);
    assign dec_lvl   = dec_prod[LVL_W+DEC_W-1:DEC_W];
    assign new_lvl   = (dec_lvl < r_min_vol) ? '0 : dec_lvl;
    assign new_ph    = s1_ph + note_step(KEY_W'(r_s1_vox));
    assign sine_addr = s1_ph[PH_W-1 -: SINE_BITS];

    assign lvl_we = r_s1_vld || key_wr;
    assign lvl_wa = r_s1_vld ? r_s1_vox : VOX_W'(key.vox);
    assign lvl_wd = r_s1_vld ? new_lvl : r_max_vol;

    // stage 2: level times sine
    assign term_c = $signed({1'b0, r_s2_lvl}) * sine_data;

    // stage 3: drop the fraction toward zero and accumulate
    always_comb begin
        term_mag = r_s3_term[TERM_W-1] ? $unsigned(-r_s3_term) : $unsigned(r_s3_term);
        term_mag = term_mag >> SIN_FRAC;
        term_tz  = r_s3_term[TERM_W-1] ? -$signed(term_mag) : $signed(term_mag);
    end

    always_comb begin
        if (r_acc[SUM_W-1:SAMPLE_W-1] == '0 || r_acc[SUM_W-1:SAMPLE_W-1] == '1) begin
            sat = r_acc[SAMPLE_W-1:0];
        end else if (r_acc[SUM_W-1]) begin
            sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_max_vol <= LVL_W'(32'h9D89D89);
            r_min_vol <= LVL_W'(32'h9D89D8);
            r_decay   <= DEC_W'(65503);
            r_lvl_vld <= '0;
            r_ph_vld  <= '0;
            r_issue   <= '0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MAX_VOL: r_max_vol <= i_cfg_data[LVL_W-1:0];
                    CFG_MIN_VOL: r_min_vol <= i_cfg_data[LVL_W-1:0];
                    CFG_DECAY:   r_decay   <= i_cfg_data[DEC_W-1:0];
                    default:     ;
                endcase
            end
            if (lvl_we) begin
                r_lvl_vld[lvl_wa] <= 1'b1;
            end
            if (r_s1_vld) begin
                r_ph_vld[r_s1_vox] <= 1'b1;
            end
            if (r_state == ST_RUN) begin
                r_issue <= issue_last ? '0 : r_issue + 1'b1;
            end
            r_s1_vld <= (r_state == ST_RUN);
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (lvl_we) begin
            r_lvl_mem[lvl_wa] <= lvl_wd;
        end
        if (r_s1_vld) begin
            r_ph_mem[r_s1_vox] <= new_ph;
        end
        r_lvl_q  <= r_lvl_mem[r_issue];
        r_ph_q   <= r_ph_mem[r_issue];
        r_lvl_ok <= r_lvl_vld[r_issue];
        r_ph_ok  <= r_ph_vld[r_issue];
    end

    always_ff @(posedge i_clk) begin
        r_s1_vox  <= r_issue;
        r_s1_last <= (r_state == ST_RUN) && issue_last;
        r_s2_lvl  <= s1_lvl;
        r_s2_last <= r_s1_last;
        r_s3_term <= term_c;
        r_s3_last <= r_s2_last;
        if (tick_start) begin
            r_acc <= '0;
        end else if (r_s3_vld) begin
            r_acc <= r_acc + SUM_W'(term_tz);
        end
        if (out_load) begin
            r_sample <= sat;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_sample    = r_sample;

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import dts_pkg::*;

    localparam int DRAIN_CYCLES = 2 * (VOICES + 4) + 8;
    localparam int TIMEOUT_NS   = 10_000_000;
    localparam int RAND_ITEMS   = 1950;
    localparam int MIN_RAND     = 400;
    localparam int PEAK_SCAN    = 600;
    localparam int REPORT_MAX   = 10;
    localparam longint PEAK_LIM = 64'sd262200;

    localparam int STALL_NONE   = 0;
    localparam int STALL_LIGHT  = 1;
    localparam int STALL_HEAVY  = 2;
    localparam int STALL_TOGGLE = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;

    localparam logic [CFG_W-1:0] MAXV_RESET  = 28'h9D89D89;
    localparam logic [CFG_W-1:0] MINV_RESET  = 28'h09D89D8;
    localparam logic [CFG_W-1:0] DECAY_RESET = 28'd65503;
    localparam logic [CFG_W-1:0] LVL_FULL    = 28'hFFFFFFF;

    logic                       i_clk      = 1'b0;
    logic                       i_rst_n    = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       i_func     = FUNC_TICK;
    logic [KEY_W-1:0]           i_key_code = '0;
    logic                       i_out_stall = 1'b0;
    logic                       i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_idx  = '0;
    logic [CFG_W-1:0]           i_cfg_data = '0;
    logic                       o_in_stall;
    logic                       o_out_valid;
    logic signed [SAMPLE_W-1:0] o_sample;

    decaying_tone_synth_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_func      (i_func),
        .i_key_code  (i_key_code),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_sample    (o_sample),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // Synth state mirror
    logic [LVL_W-1:0] voice_lvl [VOICES];
    logic [PH_W-1:0]  voice_ph  [VOICES];
    logic [PH_W-1:0]  ph_step   [VOICES];
    logic [PH_W-1:0]  note_tab  [14];
    int               sine_tab  [SINE_ENTRIES];
    longint           atan_tab  [CORDIC_STEPS];
    logic [LVL_W-1:0] vol_max_r;
    logic [LVL_W-1:0] vol_min_r;
    logic [DEC_W-1:0] decay_r;

    logic signed [SAMPLE_W-1:0] samples_due [$];
    logic signed [SAMPLE_W-1:0] sample_exp;
    int bad_count  = 0;
    int items_sent = 0;
    int burst_left = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

    function automatic longint shift_tz(input longint v, input int s);
        if (v >= 0) begin
            return v >>> s;
        end
        return -((-v) >>> s);
    endfunction

    function automatic int cordic_q15(input logic [31:0] ang);
        longint a, x, y, z, xs, ys, s;
        bit     flip;
        int     i;
        a = longint'($signed(ang));
        flip = 1'b0;
        // fold into the right half plane, negate at the end
        if (a > 64'sd1073741824) begin
            a = a - 64'sd2147483648;
            flip = 1'b1;
        end else if (a < -64'sd1073741824) begin
            a = a + 64'sd2147483648;
            flip = 1'b1;
        end
        x = 64'sd652032874;
        y = 0;
        z = a;
        for (i = 0; i < CORDIC_STEPS; i++) begin
            xs = shift_tz(x, i);
            ys = shift_tz(y, i);
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - atan_tab[i];
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + atan_tab[i];
            end
        end
        s = shift_tz(y, SIN_FRAC);
        if (s > 32767) s = 32767;
        if (s < -32767) s = -32767;
        return int'(flip ? -s : s);
    endfunction

    function automatic int voice_of(input logic [KEY_W-1:0] code);
        if (code >= 3 && code <= 8 && code != 5) begin
            return int'(code) - 3;
        end
        if (code >= 16 && code <= 23) begin
            return int'(code) - 10;
        end
        return -1;
    endfunction

    // n = 0..12 walks every key that reaches a voice
    function automatic logic [KEY_W-1:0] mapped_code(input int n);
        if (n < 2) return KEY_W'(3 + n);
        if (n < 5) return KEY_W'(4 + n);
        return KEY_W'(11 + n);
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return mapped_code($urandom_range(0, 12));
        if (r < 78) return KEY_W'(5);
        return KEY_W'($urandom_range(0, 255));
    endfunction

    task automatic build_model();
        int i;
        atan_tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                     10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
                     41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
        note_tab = '{32'd140459174, 32'd148811275, 32'd0, 32'd157660089, 32'd167035036,
                     32'd176967470, 32'd187490462, 32'd198639231, 32'd210450928,
                     32'd222965013, 32'd236223201, 32'd250269784, 32'd265151578,
                     32'd280918295};
        for (i = 0; i < VOICES; i++) begin
            ph_step[i]   = (i < 14) ? note_tab[i] : '0;
            voice_lvl[i] = '0;
            voice_ph[i]  = '0;
        end
        vol_max_r = MAXV_RESET;
        vol_min_r = MINV_RESET;
        decay_r   = DEC_W'(DECAY_RESET);
        for (i = 0; i < SINE_ENTRIES; i++) begin
            sine_tab[i] = cordic_q15(32'(i) << (PH_W - SINE_BITS));
        end
    endtask

    task automatic press_key(input logic [KEY_W-1:0] code);
        int v;
        v = voice_of(code);
        if (v >= 0 && v < VOICES) begin
            voice_lvl[v] = vol_max_r;
        end
    endtask

    task automatic synth_tick(output logic signed [SAMPLE_W-1:0] smp);
        longint acc, term, lv;
        int     v;
        acc = 0;
        for (v = 0; v < VOICES; v++) begin
            term = longint'(voice_lvl[v]) * longint'(sine_tab[voice_ph[v] >> (PH_W - SINE_BITS)]);
            acc = acc + shift_tz(term, SIN_FRAC);
            voice_ph[v] = voice_ph[v] + ph_step[v];
            lv = (longint'(voice_lvl[v]) * longint'(decay_r)) >>> 16;
            voice_lvl[v] = (lv < longint'(vol_min_r)) ? '0 : lv[LVL_W-1:0];
        end
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        smp = acc[SAMPLE_W-1:0];
    endtask

    // Ticks until the raw sine sum crosses the saturation point, or -1.
    function automatic int ticks_to_peak(input bit positive);
        logic [PH_W-1:0] ph [VOICES];
        longint s;
        int k, v;
        ph = voice_ph;
        for (k = 0; k < PEAK_SCAN; k++) begin
            s = 0;
            for (v = 0; v < VOICES; v++) begin
                s = s + sine_tab[ph[v] >> (PH_W - SINE_BITS)];
            end
            if (positive ? (s > PEAK_LIM) : (s < -PEAK_LIM)) return k;
            for (v = 0; v < VOICES; v++) begin
                ph[v] = ph[v] + ph_step[v];
            end
        end
        return -1;
    endfunction

    task automatic send_request(input logic func, input logic [KEY_W-1:0] code);
        int gap;
        logic signed [SAMPLE_W-1:0] smp;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_func     <= func;
        i_key_code <= code;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (func == FUNC_KEY) begin
            press_key(code);
        end else begin
            synth_tick(smp);
            samples_due.push_back(smp);
        end
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 10);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    // Hold requests off until every sample is out and the block is quiet.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (samples_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MAX_VOL: vol_max_r = data;
            CFG_MIN_VOL: vol_min_r = data;
            CFG_DECAY:   decay_r   = data[DEC_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [CFG_W-1:0] maxv, input logic [CFG_W-1:0] minv,
                              input logic [CFG_W-1:0] dec);
        settle();
        write_reg(CFG_MAX_VOL, maxv);
        write_reg(CFG_MIN_VOL, minv);
        write_reg(CFG_DECAY, dec);
    endtask

    task automatic test_silence();
        send_request(FUNC_TICK, 8'h00);
        send_request(FUNC_TICK, 8'hFF);
    endtask

    task automatic test_key_codes();
        logic [KEY_W-1:0] codes [$];
        int i;
        codes = '{8'd0, 8'd2, 8'd3, 8'd5, 8'd8, 8'd9, 8'd15, 8'd16, 8'd23, 8'd24, 8'd255};
        for (i = 0; i < codes.size(); i++) begin
            send_request(FUNC_KEY, codes[i]);
        end
        send_request(FUNC_TICK, 8'h00);
        send_request(FUNC_TICK, 8'h00);
    endtask

    task automatic test_registers();
        // unused index must leave the peak level alone; decay data wider than 16 bits
        set_config(28'h1234567, 28'h0, 28'hFFFFFFF);
        write_reg(CFG_NONE, LVL_FULL);
        send_request(FUNC_KEY, 8'd4);
        send_request(FUNC_KEY, 8'd17);
        send_request(FUNC_KEY, 8'd22);
        send_request(FUNC_TICK, 8'h00);
        send_request(FUNC_TICK, 8'h00);
        set_config(28'h0, LVL_FULL, 28'hABC0000);
        send_request(FUNC_KEY, 8'd6);
        send_request(FUNC_TICK, 8'h00);
        // a full level sounds once, then drops below the floor
        set_config(LVL_FULL, LVL_FULL, 28'h000FFFF);
        send_request(FUNC_KEY, 8'd7);
        send_request(FUNC_TICK, 8'h00);
        send_request(FUNC_TICK, 8'h00);
    endtask

    task automatic hunt_peak(input bit positive);
        int left, n;
        left = ticks_to_peak(positive);
        if (left < 0) return;
        while (left > 0) begin
            if ($urandom_range(0, 3) == 0) begin
                send_request(FUNC_KEY, rand_key());
            end else begin
                send_request(FUNC_TICK, KEY_W'($urandom_range(0, 255)));
                left--;
            end
        end
        for (n = 0; n < 13; n++) begin
            send_request(FUNC_KEY, mapped_code(n));
        end
        send_request(FUNC_TICK, 8'h00);
    endtask

    task automatic test_saturation();
        set_config(LVL_FULL, 28'h0, 28'h000FFFF);
        hunt_peak(1'b1);
        hunt_peak(1'b0);
    endtask

    task automatic test_random();
        int budget, per_phase, p, i;
        logic [CFG_W-1:0] mv;
        budget = RAND_ITEMS - items_sent;
        if (budget < MIN_RAND) budget = MIN_RAND;
        per_phase = budget / 6;
        for (p = 0; p < 6; p++) begin
            case (p)
                0: set_config(MAXV_RESET, MINV_RESET, DECAY_RESET);
                1: set_config(LVL_FULL, 28'h0, 28'h000FFFF);
                2: begin
                    mv = CFG_W'($urandom_range(0, LVL_FULL));
                    set_config(mv, CFG_W'($urandom_range(0, mv / 8)),
                               CFG_W'($urandom_range(60000, 65535)));
                end
                3: set_config(CFG_W'($urandom_range(0, LVL_FULL)),
                              CFG_W'($urandom_range(0, LVL_FULL)),
                              CFG_W'($urandom_range(0, LVL_FULL)));
                4: set_config(CFG_W'($urandom_range(0, 1000)), 28'h0, 28'h000FFFF);
                default: set_config(LVL_FULL, LVL_FULL, 28'h0);
            endcase
            for (i = 0; i < per_phase; i++) begin
                if ($urandom_range(0, 99) < 55) begin
                    send_request(FUNC_TICK, KEY_W'($urandom_range(0, 255)));
                end else begin
                    send_request(FUNC_KEY, rand_key());
                end
                if ($urandom_range(0, 149) == 0) settle();
            end
        end
    endtask

    // Receiver stall pattern, independent of the sender
    initial begin
        int mode, len;
        forever begin
            mode = $urandom_range(STALL_NONE, STALL_TOGGLE);
            len  = $urandom_range(10, 150);
            repeat (len) begin
                @(negedge i_clk);
                case (mode)
                    STALL_NONE:  i_out_stall <= 1'b0;
                    STALL_LIGHT: i_out_stall <= ($urandom_range(0, 99) < 30);
                    STALL_HEAVY: i_out_stall <= ($urandom_range(0, 99) < 80);
                    default:     i_out_stall <= ~i_out_stall;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (samples_due.size() == 0) begin
                bad_count++;
                if (bad_count <= REPORT_MAX)
                    $display("unexpected sample %0d at %0t", o_sample, $realtime);
            end else begin
                sample_exp = samples_due.pop_front();
                if (o_sample !== sample_exp) begin
                    bad_count++;
                    if (bad_count <= REPORT_MAX)
                        $display("sample mismatch at %0t: expected %0d got %0d",
                                 $realtime, sample_exp, o_sample);
                end
            end
        end
    end

    initial begin
        build_model();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_silence();
        test_key_codes();
        test_registers();
        test_saturation();
        test_random();
        settle();
        if (bad_count == 0 && samples_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
